FILE: hw/rtl/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg
// Item types and character codes shared by the chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package chd_pkg;

  // Width of the decoded length reported on every result
  localparam int unsigned CNT_W = 32;

  // Characters that steer the size line parser
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  // One raw byte of the chunked body
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } chd_in_t;

  // One decoded result
  typedef struct packed {
    logic [7:0]       out_byte;
    logic             is_data;
    logic             done_res;
    logic [CNT_W-1:0] body_length;
  } chd_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/chd_step.sv
// ----------------------------------------------------------------------------
// chd_step
// Decoder state and the single-pass update for one body byte: size line
// parsing, payload pass-through, CR/LF skipping and end-of-body detection.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_step #(
  parameter int unsigned LEN_W = 32
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              fire_i,
  input  chd_pkg::chd_in_t item_i,
  output logic             res_valid_o,
  output chd_pkg::chd_out_t res_o
);
  import chd_pkg::*;

  // Parser phases
  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_SIGNED = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_TRAIL  = 3'd5;

  // Digit tracking codes
  localparam logic [1:0] DG_NONE   = 2'd0;
  localparam logic [1:0] DG_ZERO   = 2'd1;
  localparam logic [1:0] DG_MANY   = 2'd2;
  localparam logic [1:0] DG_PREFIX = 2'd3;

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [4:0] r;
    r = '0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, 4'(ch - 8'h30)};
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      r = {1'b1, 4'(ch - 8'h57)};
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      r = {1'b1, 4'(ch - 8'h37)};
    end
    return r;
  endfunction

  logic [2:0]       phase_q, phase_d, phase_w;
  logic [LEN_W-1:0] chunk_q, chunk_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       digits_q, digits_d;
  logic             finished_q, finished_d;

  logic [7:0]       ch;
  logic [4:0]       hex;
  logic             is_blank;
  logic [LEN_W+3:0] shifted;
  logic             data;
  logic             ending;

  assign ch       = item_i.in_byte;
  assign hex      = hex_decode(ch);
  assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VT) ||
                    (ch == CH_FF) || (ch == CH_CR);
  // Append one hex digit; any bit shifted into the top nibble means saturation
  assign shifted  = {chunk_q, 4'b0000} | {{LEN_W{1'b0}}, hex[3:0]};

  // Compute next state and the result for the byte in the input register
  always_comb begin
    phase_d    = phase_q;
    chunk_d    = chunk_q;
    cnt_d      = cnt_q;
    digits_d   = digits_q;
    finished_d = finished_q;
    data       = 1'b0;
    ending     = 1'b0;

    // Leave the CR/LF skip on any other byte and parse it as a line start
    phase_w = phase_q;
    if (phase_q == PH_TRAIL && ch != CH_CR && ch != CH_LF) begin
      phase_w = PH_LEAD;
    end
    phase_d = phase_w;

    if (!finished_q) begin
      if (phase_w == PH_DATA) begin
        // Pass a payload byte
        data    = 1'b1;
        cnt_d   = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);
        chunk_d = chunk_q - LEN_W'(1);
        if (chunk_q == LEN_W'(1)) begin
          phase_d = PH_TRAIL;
        end
      end else if (phase_w != PH_TRAIL) begin
        if (ch == CH_LF) begin
          // End of size line
          if (chunk_q == '0) begin
            ending = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
          digits_d = DG_NONE;
        end else begin
          unique case (phase_w) inside
            PH_LEAD, PH_SIGNED: begin
              if (phase_w == PH_LEAD && is_blank) begin
                phase_d = phase_w;
              end else if (phase_w == PH_LEAD && ch == CH_PLUS) begin
                phase_d = PH_SIGNED;
              end else if (phase_w == PH_LEAD && ch == CH_MINUS) begin
                ending = 1'b1;
              end else if (hex[4]) begin
                chunk_d  = {{(LEN_W-4){1'b0}}, hex[3:0]};
                digits_d = (hex[3:0] == 4'd0) ? DG_ZERO : DG_MANY;
                phase_d  = PH_DIGITS;
              end else begin
                chunk_d = '0;
                phase_d = PH_SKIP;
              end
            end
            PH_DIGITS: begin
              if (digits_q == DG_ZERO && (ch == CH_X_LO || ch == CH_X_UP)) begin
                digits_d = DG_PREFIX;
              end else if (hex[4]) begin
                chunk_d  = (shifted[LEN_W+3:LEN_W] != 4'd0) ? '1 : shifted[LEN_W-1:0];
                digits_d = DG_MANY;
              end else begin
                phase_d = PH_SKIP;
              end
            end
            default: begin
              phase_d = phase_w;
            end
          endcase
        end
      end
      if (item_i.last_byte) begin
        ending = 1'b1;
      end
      if (ending) begin
        finished_d = 1'b1;
      end
    end
  end

  // Emit a result on a payload byte or at the end of the body
  assign res_valid_o       = data || ending;
  assign res_o.out_byte    = data ? ch : 8'h00;
  assign res_o.is_data     = data;
  assign res_o.done_res    = ending;
  assign res_o.body_length = cnt_d;

  // Advance state when the byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LEAD;
      chunk_q    <= '0;
      cnt_q      <= '0;
      digits_q   <= DG_NONE;
      finished_q <= 1'b0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      chunk_q    <= chunk_d;
      cnt_q      <= cnt_d;
      digits_q   <= digits_d;
      finished_q <= finished_d;
    end
  end

  a_data_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> chunk_q != '0)
    else $error("payload phase with no bytes left");

  a_finished_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> !res_valid_o)
    else $error("result produced after end of body");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |=> cnt_q >= $past(cnt_q))
    else $error("decoded length decreased");

endmodule

`default_nettype wire

FILE: hw/rtl/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP/1.1 chunked body byte by byte into payload bytes and a
// final decoded length.
// ----------------------------------------------------------------------------
// The decoder takes one raw body byte per clock cycle while neither side
// stalls, and gives at most one item per byte: a payload byte, the
// end-of-body marker, or both. Each byte waits in the input register, where
// a single pass of the parser updates the decoder state and loads the result
// register, so a result passes through the input register and then the
// result register before it is on the output. The parser state loop closes
// in that one pass, which sets the rate of one byte per cycle without stalls.
// A stall on the output holds the result register and, through it, the
// input. After the end of the body every byte is accepted and dropped until
// reset. No clearing pass is needed after reset.
`default_nettype none

module http_chunked_body_decoder #(
  parameter int unsigned LEN_W = 32
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  chd_pkg::chd_in_t  in_item_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output chd_pkg::chd_out_t out_item_o
);
  import chd_pkg::*;

  logic     in_valid_q;
  chd_in_t  in_item_q;
  logic     out_valid_q;
  chd_out_t out_item_q;
  logic     out_free;
  logic     fire;
  logic     res_valid;
  chd_out_t res;

  // Result register can take a new item this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // Hold the input item until the parser consumes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  chd_step #(
    .LEN_W (LEN_W)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (in_item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Load the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

FILE: bench/http_chunked_body_decoder_chk.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_chk
// Watches both channels of the chunked body decoder, predicts each result
// from the accepted raw bytes and compares it with the decoded item.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_chk #(
  parameter int unsigned LEN_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  chd_pkg::chd_in_t  in_item_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  chd_pkg::chd_out_t out_item_i,
  output int unsigned       fail_cnt_o,
  output int unsigned       pend_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import chd_pkg::*;

  typedef enum logic [2:0] {
    SZ_START, SZ_SIGNED, SZ_DIGITS, SZ_SKIP, BODY_DATA, BODY_TRAIL
  } phase_e;

  typedef enum logic [1:0] {DG_NONE, DG_ZERO, DG_MANY, DG_PREFIX} digits_e;

  phase_e           phase;
  logic [LEN_W-1:0] chunk_left;
  logic [CNT_W-1:0] out_len;
  digits_e          digits;
  bit               body_done;
  chd_out_t         decoded_q[$];
  chd_out_t         predicted;
  chd_out_t         wanted;
  int unsigned      fail_cnt;

  assign fail_cnt_o = fail_cnt;

  // Advance the decoder state by one raw byte; return 1 when it yields an item
  function automatic bit decode_byte(input chd_in_t raw, output chd_out_t res);
    logic [7:0]       c;
    bit               data;
    bit               ending;
    bit               blank;
    int               d;
    logic [LEN_W+4:0] grown;
    c      = raw.in_byte;
    data   = 1'b0;
    ending = 1'b0;
    res    = '0;
    if (body_done) return 1'b0;

    // Trailing CR/LF ends at the first other byte, which opens a size line
    if (phase == BODY_TRAIL && c != CH_CR && c != CH_LF) phase = SZ_START;

    if (c >= "0" && c <= "9") d = int'(c - "0");
    else if (c >= "a" && c <= "f") d = c - "a" + 10;
    else if (c >= "A" && c <= "F") d = c - "A" + 10;
    else d = -1;
    blank = (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR);

    if (phase == BODY_DATA) begin
      data = 1'b1;
      if (out_len != '1) out_len = out_len + CNT_W'(1);
      chunk_left = chunk_left - LEN_W'(1);
      if (chunk_left == '0) phase = BODY_TRAIL;
    end else if (phase != BODY_TRAIL) begin
      if (c == CH_LF) begin
        // Newline closes the size line: zero ends the body
        if (chunk_left == '0) ending = 1'b1;
        else phase = BODY_DATA;
        digits = DG_NONE;
      end else begin
        case (phase)
          SZ_START, SZ_SIGNED: begin
            if (phase == SZ_START && blank) begin
              // drop leading blank
            end else if (phase == SZ_START && c == CH_PLUS) begin
              phase = SZ_SIGNED;
            end else if (phase == SZ_START && c == CH_MINUS) begin
              ending = 1'b1;
            end else if (d >= 0) begin
              chunk_left = LEN_W'(d);
              digits     = (d == 0) ? DG_ZERO : DG_MANY;
              phase      = SZ_DIGITS;
            end else begin
              chunk_left = '0;
              phase      = SZ_SKIP;
            end
          end
          SZ_DIGITS: begin
            if (digits == DG_ZERO && (c == CH_X_LO || c == CH_X_UP)) begin
              digits = DG_PREFIX;
            end else if (d >= 0) begin
              // Saturate the size at the all-ones count
              grown = ({5'b0, chunk_left} << 4) + (LEN_W + 5)'(d);
              chunk_left = (grown[LEN_W+4:LEN_W] != '0) ? '1 : grown[LEN_W-1:0];
              digits = DG_MANY;
            end else begin
              phase = SZ_SKIP;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (raw.last_byte) ending = 1'b1;
    if (ending) body_done = 1'b1;
    if (!data && !ending) return 1'b0;
    res.out_byte    = data ? c : 8'h00;
    res.is_data     = data;
    res.done_res    = ending;
    res.body_length = out_len;
    return 1'b1;
  endfunction

  task automatic note_failure(input string msg);
    fail_cnt = fail_cnt + 1;
    if (fail_cnt <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // Predict on each accepted raw byte, compare each accepted decoded item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase      = SZ_START;
      chunk_left = '0;
      out_len    = '0;
      digits     = DG_NONE;
      body_done  = 1'b0;
      fail_cnt   = 0;
      decoded_q.delete();
      pend_cnt_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (decode_byte(in_item_i, predicted)) decoded_q.push_back(predicted);
      end
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          note_failure($sformatf("unexpected item: byte %02h data %0b done %0b len %0d",
                                 out_item_i.out_byte, out_item_i.is_data,
                                 out_item_i.done_res, out_item_i.body_length));
        end else begin
          wanted = decoded_q.pop_front();
          if (out_item_i.out_byte !== wanted.out_byte ||
              out_item_i.is_data !== wanted.is_data ||
              out_item_i.done_res !== wanted.done_res ||
              out_item_i.body_length !== wanted.body_length) begin
            note_failure($sformatf(
              {"mismatch: expected byte %02h data %0b done %0b len %0d,",
               " got byte %02h data %0b done %0b len %0d"},
              wanted.out_byte, wanted.is_data, wanted.done_res, wanted.body_length,
              out_item_i.out_byte, out_item_i.is_data, out_item_i.done_res,
              out_item_i.body_length));
          end
        end
      end
      pend_cnt_o = decoded_q.size();
    end
  end

endmodule

FILE: bench/http_chunked_body_decoder_tb.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_tb
// Feeds one chunked body into the decoder: a directed opening, then random
// well-formed chunks, then one randomly chosen way of ending the body and a
// few bytes that must be dropped. Random gaps and output stalls except near the end.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chd_pkg::*;

  localparam int unsigned LEN_W       = 32;
  localparam int unsigned BODY_BYTES  = 1100;
  localparam int unsigned CALM_BYTES  = 950;
  localparam int unsigned CYCLE_LIMIT = 300000;

  typedef enum int {
    END_ZERO_CHUNK, END_MINUS, END_NO_DIGITS, END_PREFIX_JUNK, END_EMPTY_LINE,
    END_HUGE_CUT, END_LAST_IN_SIZE, END_LAST_IN_TRAIL, END_PREFIX_NO_DIGIT,
    END_PLUS_JUNK
  } body_end_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  chd_in_t     in_item;
  logic        out_valid;
  logic        out_stall;
  chd_out_t    out_item;
  bit          idle_on;
  int unsigned sent_cnt;
  int unsigned cycle_cnt;
  int unsigned fail_cnt;
  int unsigned pend_cnt;

  http_chunked_body_decoder #(
    .LEN_W(LEN_W)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  http_chunked_body_decoder_chk #(
    .LEN_W(LEN_W)
  ) i_chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_item_i (out_item),
    .fail_cnt_o (fail_cnt),
    .pend_cnt_o (pend_cnt)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Count cycles and end a hung run
  initial cycle_cnt = 0;
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt == CYCLE_LIMIT);
    $display("http_chunked_body_decoder_tb failed");
    $finish;
  end

  // Stall the decoded side in random bursts
  initial begin
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Send one raw byte; entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic fin);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{in_byte: b, last_byte: fin};
    do @(posedge clk); while (in_stall);
    sent_cnt = sent_cnt + 1;
    @(negedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  // One well-formed chunk with random size line decoration and payload
  task automatic push_chunk();
    int unsigned size;
    string       digits;
    logic [7:0]  ch;
    size = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 4))
        0: push_byte(CH_SPACE, 1'b0);
        1: push_byte(CH_TAB, 1'b0);
        2: push_byte(CH_VT, 1'b0);
        3: push_byte(CH_FF, 1'b0);
        default: push_byte(CH_CR, 1'b0);
      endcase
    end
    if ($urandom_range(0, 3) == 0) push_byte(CH_PLUS, 1'b0);
    if ($urandom_range(0, 3) == 0) begin
      push_byte("0", 1'b0);
      push_byte($urandom_range(0, 1) ? CH_X_UP : CH_X_LO, 1'b0);
    end
    repeat ($urandom_range(0, 4) == 0 ? $urandom_range(1, 2) : 0) push_byte("0", 1'b0);
    digits = $sformatf("%0h", size);
    for (int i = 0; i < digits.len(); i++) begin
      ch = digits[i];
      if (ch >= "a" && ch <= "f" && $urandom_range(0, 1)) ch = ch - 8'h20;
      push_byte(ch, 1'b0);
    end
    // Optional extension: everything up to the newline is skipped
    if ($urandom_range(0, 2) == 0) begin
      push_byte(";", 1'b0);
      repeat ($urandom_range(0, 4)) begin
        ch = 8'($urandom_range(0, 255));
        push_byte((ch == CH_LF) ? CH_SPACE : ch, 1'b0);
      end
    end
    if ($urandom_range(0, 1)) push_byte(CH_CR, 1'b0);
    push_byte(CH_LF, 1'b0);
    repeat (size) push_byte(8'($urandom_range(0, 255)), 1'b0);
    repeat ($urandom_range(0, 3)) push_byte($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
  endtask

  // Stimulus and verdict
  initial begin
    body_end_e how;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    idle_on  = 1'b1;
    sent_cnt = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening: every blank, sign, both prefix cases, extreme bytes
    push_byte(CH_SPACE, 1'b0);
    push_byte(CH_TAB, 1'b0);
    push_byte(CH_VT, 1'b0);
    push_byte(CH_FF, 1'b0);
    push_byte(CH_CR, 1'b0);
    push_byte(CH_PLUS, 1'b0);
    push_text("0X3");
    push_byte(CH_LF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_LF, 1'b0);
    push_byte(CH_CR, 1'b0);
    push_byte(CH_LF, 1'b0);
    push_text("0x2;Z");
    push_byte(CH_LF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_text("01");
    push_byte(CH_CR, 1'b0);
    push_byte(CH_LF, 1'b0);
    push_byte(8'h55, 1'b0);

    // Random well-formed chunks; calm down near the end
    while (sent_cnt < BODY_BYTES) begin
      if (sent_cnt >= CALM_BYTES) idle_on = 1'b0;
      push_chunk();
    end

    // Close the body in one of its many ways
    how = body_end_e'($urandom_range(0, 9));
    case (how)
      END_ZERO_CHUNK: begin
        push_byte("0", 1'b0);
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
      end
      END_MINUS: begin
        push_byte(CH_MINUS, 1'b0);
        push_text("5");
        push_byte(CH_LF, 1'b0);
      end
      END_NO_DIGITS: begin
        push_text("zq7");
        push_byte(CH_LF, 1'b0);
      end
      END_PREFIX_JUNK: begin
        push_text("0xg");
        push_byte(CH_LF, 1'b0);
      end
      END_EMPTY_LINE: begin
        push_byte(CH_LF, 1'b0);
      end
      END_HUGE_CUT: begin
        push_text("+123456789aBc");
        push_byte(CH_LF, 1'b0);
        repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)), 1'b0);
        push_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      END_LAST_IN_SIZE: begin
        push_text("1");
        push_byte("f", 1'b1);
      end
      END_LAST_IN_TRAIL: begin
        push_byte(CH_CR, 1'b1);
      end
      END_PREFIX_NO_DIGIT: begin
        push_text("0X");
        push_byte(CH_LF, 1'b0);
      end
      default: begin
        push_text("+-3");
        push_byte(CH_LF, 1'b0);
      end
    endcase

    // Bytes after the end are dropped
    repeat ($urandom_range(4, 16)) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    in_valid <= 1'b0;

    // Drain, then give any stray item time to show up
    do @(negedge clk); while (pend_cnt != 0);
    repeat (10) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("http_chunked_body_decoder_tb passed");
    end else begin
      $display("http_chunked_body_decoder_tb failed");
    end
    $finish;
  end

endmodule
